// ===== design/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared constants, request and result types, action codes and FSM states.
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int DUR_W      = 16;
    localparam int TIMER_W    = 21;
    localparam int SUM_W      = DUR_W + IDX_W;
    localparam int CMP_W      = (SUM_W > TIMER_W) ? SUM_W : TIMER_W;
    localparam int MOD_CNT_W  = $clog2(TIMER_W);

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_STOP   = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_RENDER = 3'd4;

    typedef struct packed {
        logic        [2:0]  action;
        logic        [15:0] amount;
        logic signed [15:0] src_x;
        logic signed [15:0] src_y;
        logic        [11:0] src_w;
        logic        [11:0] src_h;
    } item_t;

    typedef struct packed {
        logic               running;
        logic               frame_valid;
        logic        [3:0]  frame_index;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic        [11:0] out_w;
        logic        [11:0] out_h;
        logic               table_full;
        logic [TIMER_W-1:0] elapsed;
    } result_t;

    typedef struct packed {
        logic [DUR_W-1:0]   duration;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic        [11:0] w;
        logic        [11:0] h;
    } frame_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK
    } state_t;

endpackage

// ===== design/sprite_frame_sequencer.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Frame table with timer, wrap and frame selection for sprite animation.
// ----------------------------------------------------------------------------
// Add, start, stop, plain ticks and unused codes: result in the cycle after start.
// A tick that wraps runs the bit-serial remainder unit before its result.
// A render walks the frame table over its one read port, a read state and a
// check state per frame visited, until the sum reaches the timer or the end.
// busy is high while a wrap or a render walk runs; done pulses for one cycle.
// Reset clears the frame count, total, timer, running flag and cyclic mode.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sfs_pkg::item_t    item,
    output logic              done,
    output sfs_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);

    localparam int IDX_W   = sfs_pkg::IDX_W;
    localparam int CNT_W   = sfs_pkg::CNT_W;
    localparam int TIMER_W = sfs_pkg::TIMER_W;
    localparam int SUM_W   = sfs_pkg::SUM_W;
    localparam int CMP_W   = sfs_pkg::CMP_W;

    sfs_pkg::state_t        state_reg, state_next;
    logic [TIMER_W-1:0]     timer_reg, timer_next;
    logic [TIMER_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   running_reg, running_next;
    logic                   cyclic_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic                   done_reg, done_next;
    sfs_pkg::result_t       result_reg, result_next;

    logic                   accept;
    logic                   wr_en;
    logic                   rd_en;
    sfs_pkg::frame_entry_t  wr_entry;
    sfs_pkg::frame_entry_t  rd_entry;
    logic                   mod_start;
    logic                   mod_done;
    logic [TIMER_W-1:0]     mod_rem;
    logic [TIMER_W:0]       timer_sum;
    logic [TIMER_W-1:0]     timer_sat;
    logic [TIMER_W:0]       total_sum;
    logic [TIMER_W-1:0]     total_sat;
    logic [SUM_W-1:0]       walk_sum;
    logic                   walk_hit;
    logic                   walk_last;
    logic [IDX_W+3:0]       idx_wide;

    assign accept    = start && (state_reg == sfs_pkg::ST_IDLE);
    assign busy      = (state_reg != sfs_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == sfs_pkg::ST_IDLE);

    assign timer_sum = {1'b0, timer_reg} + (TIMER_W + 1)'(item.amount);
    assign timer_sat = (timer_sum > {1'b0, sfs_pkg::TIMER_MAX}) ? sfs_pkg::TIMER_MAX
                                                               : timer_sum[TIMER_W-1:0];
    assign total_sum = {1'b0, total_reg} + (TIMER_W + 1)'(item.amount);
    assign total_sat = (total_sum > {1'b0, sfs_pkg::TIMER_MAX}) ? sfs_pkg::TIMER_MAX
                                                               : total_sum[TIMER_W-1:0];

    // Running prefix sum of durations against the timer during a render walk.
    assign walk_sum  = sum_reg + SUM_W'(rd_entry.duration);
    assign walk_hit  = CMP_W'(walk_sum) >= CMP_W'(timer_reg);
    assign walk_last = (CNT_W'(idx_reg) + 1'b1) == count_reg;
    assign idx_wide  = {4'b0000, idx_reg};

    assign wr_entry.duration = item.amount;
    assign wr_entry.x        = item.src_x;
    assign wr_entry.y        = item.src_y;
    assign wr_entry.w        = item.src_w;
    assign wr_entry.h        = item.src_h;

    always_comb
    begin
        state_next   = state_reg;
        timer_next   = timer_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        running_next = running_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        mod_start    = 1'b0;

        case (state_reg)
            sfs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    done_next   = 1'b1;
                    case (item.action)
                        sfs_pkg::ACT_ADD:
                        begin
                            if (count_reg >= CNT_W'(sfs_pkg::MAX_FRAMES))
                            begin
                                result_next.table_full = 1'b1;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                total_next = total_sat;
                            end
                        end
                        sfs_pkg::ACT_START:
                        begin
                            running_next = 1'b1;
                            timer_next   = '0;
                        end
                        sfs_pkg::ACT_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        sfs_pkg::ACT_TICK:
                        begin
                            if (running_reg)
                            begin
                                timer_next = timer_sat;
                                if (timer_sat >= total_reg)
                                begin
                                    if (!cyclic_reg)
                                    begin
                                        running_next = 1'b0;
                                    end
                                    else if (total_reg == '0)
                                    begin
                                        timer_next = '0;
                                    end
                                    else
                                    begin
                                        mod_start  = 1'b1;
                                        done_next  = 1'b0;
                                        state_next = sfs_pkg::ST_MOD;
                                    end
                                end
                            end
                        end
                        sfs_pkg::ACT_RENDER:
                        begin
                            if (running_reg && (count_reg != '0))
                            begin
                                idx_next   = '0;
                                sum_next   = '0;
                                done_next  = 1'b0;
                                state_next = sfs_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    result_next.running = running_next;
                    result_next.elapsed = timer_next;
                end
            end
            sfs_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    timer_next          = mod_rem;
                    result_next.elapsed = mod_rem;
                    done_next           = 1'b1;
                    state_next          = sfs_pkg::ST_IDLE;
                end
            end
            sfs_pkg::ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = sfs_pkg::ST_CHECK;
            end
            sfs_pkg::ST_CHECK:
            begin
                if (walk_hit || walk_last)
                begin
                    result_next.frame_valid = 1'b1;
                    result_next.frame_index = idx_wide[3:0];
                    result_next.out_x       = rd_entry.x;
                    result_next.out_y       = rd_entry.y;
                    result_next.out_w       = rd_entry.w;
                    result_next.out_h       = rd_entry.h;
                    done_next               = 1'b1;
                    state_next              = sfs_pkg::ST_IDLE;
                end
                else
                begin
                    sum_next   = walk_sum;
                    idx_next   = idx_reg + 1'b1;
                    state_next = sfs_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = sfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sfs_pkg::ST_IDLE;
            timer_reg   <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
            running_reg <= 1'b0;
            cyclic_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            timer_reg   <= timer_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            running_reg <= running_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                cyclic_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
    end

    sfs_frame_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    sfs_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (timer_sat),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign done   = done_reg;
    assign result = result_reg;

    // The frame count never passes the table size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(sfs_pkg::MAX_FRAMES))
        else $error("frame count exceeds table size");

    // A result appears only once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A render while stopped completes in the next cycle with no frame.
    a_render_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.action == sfs_pkg::ACT_RENDER && !running_reg)
        |=> (done && !result.frame_valid))
        else $error("render while stopped did not complete at once");

    // A result without a frame carries a zero index and rectangle.
    a_no_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.frame_valid) |-> (result.frame_index == '0 &&
        result.out_x == '0 && result.out_y == '0 && result.out_w == '0 &&
        result.out_h == '0))
        else $error("non-render result carries frame data");

    // The remainder unit is only started from idle by an accepted tick.
    a_mod_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        mod_start |-> (accept && item.action == sfs_pkg::ACT_TICK))
        else $error("wrap started without a tick request");

endmodule

// ===== design/sfs_frame_ram.sv =====
// ----------------------------------------------------------------------------
// Sprite frame table
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfs_frame_ram (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [sfs_pkg::IDX_W-1:0]    wr_addr,
    input  sfs_pkg::frame_entry_t        wr_data,
    input  logic                         rd_en,
    input  logic [sfs_pkg::IDX_W-1:0]    rd_addr,
    output sfs_pkg::frame_entry_t        rd_data
);

    sfs_pkg::frame_entry_t mem [sfs_pkg::MAX_FRAMES];
    sfs_pkg::frame_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sfs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// Timer wrap unit
// Restoring remainder, one quotient bit per cycle, dividend MSB first.
// ----------------------------------------------------------------------------
module sfs_mod_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sfs_pkg::TIMER_W-1:0]   dividend,
    input  logic [sfs_pkg::TIMER_W-1:0]   divisor,
    output logic                          done,
    output logic [sfs_pkg::TIMER_W-1:0]   remainder
);

    localparam int W = sfs_pkg::TIMER_W;

    logic                             active_reg;
    logic                             done_reg;
    logic [sfs_pkg::MOD_CNT_W-1:0]    cnt_reg;
    logic [W-1:0]                     rem_reg;
    logic [W-1:0]                     dvd_reg;
    logic [W-1:0]                     div_reg;
    logic [W:0]                       trial;
    logic [W-1:0]                     rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == sfs_pkg::MOD_CNT_W'(W - 1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== verif/sprite_frame_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives a short directed script, then random requests in phases alternating
// the wrap mode. A behavioral copy of the frame table, timer and running flag
// predicts results the script leaves open; all are checked field by field.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Action codes that the block treats as no operation.
    localparam logic [2:0] ACT_RSVD5 = 3'd5;
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    localparam int PHASES          = 6;
    localparam int PHASE_REQUESTS  = 108;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct {
        bit               is_cfg;
        bit               cfg_val;
        sfs_pkg::item_t   req;
        bit               typed;
        sfs_pkg::result_t want;
    } step_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    sfs_pkg::item_t   item;
    logic             done;
    sfs_pkg::result_t result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_data;

    // Behavioral copy of the sequencer state.
    sfs_pkg::frame_entry_t frames [sfs_pkg::MAX_FRAMES];
    int unsigned  frames_held = 0;
    int unsigned  total_len   = 0;
    int unsigned  anim_clock  = 0;
    bit           anim_on     = 1'b0;
    bit           wrap_mode   = 1'b0;

    sfs_pkg::result_t expected_results [$];
    step_t            script [$];
    int unsigned      requests_taken = 0;
    int unsigned      cfg_writes     = 0;
    int unsigned      mismatches     = 0;
    bit               use_typed      = 1'b0;
    sfs_pkg::result_t typed_want     = '0;

    sprite_frame_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always #6 clk = ~clk;

    function automatic int unsigned clip_timer(int unsigned v);
        return (v > sfs_pkg::TIMER_MAX) ? sfs_pkg::TIMER_MAX : v;
    endfunction

    // Applies one request to the local state and returns the result it causes.
    function automatic sfs_pkg::result_t advance_sequencer(sfs_pkg::item_t req);
        sfs_pkg::result_t r;
        int unsigned      sum;
        int unsigned      pick;
        bit               found;
        r = '0;
        case (req.action)
            sfs_pkg::ACT_ADD:
            begin
                if (frames_held >= sfs_pkg::MAX_FRAMES)
                    r.table_full = 1'b1;
                else
                begin
                    frames[frames_held].duration = req.amount;
                    frames[frames_held].x        = req.src_x;
                    frames[frames_held].y        = req.src_y;
                    frames[frames_held].w        = req.src_w;
                    frames[frames_held].h        = req.src_h;
                    frames_held++;
                    total_len = clip_timer(total_len + req.amount);
                end
            end
            sfs_pkg::ACT_START:
            begin
                anim_on    = 1'b1;
                anim_clock = 0;
            end
            sfs_pkg::ACT_STOP:
                anim_on = 1'b0;
            sfs_pkg::ACT_TICK:
            begin
                if (anim_on)
                begin
                    anim_clock = clip_timer(anim_clock + req.amount);
                    if (anim_clock >= total_len)
                    begin
                        if (!wrap_mode)
                            anim_on = 1'b0;
                        else if (total_len == 0)
                            anim_clock = 0;
                        else
                            anim_clock = anim_clock % total_len;
                    end
                end
            end
            sfs_pkg::ACT_RENDER:
            begin
                if (anim_on && frames_held > 0)
                begin
                    sum   = 0;
                    pick  = 0;
                    found = 1'b0;
                    for (int i = 0; i < frames_held; i++)
                    begin
                        if (!found)
                        begin
                            pick = i;
                            sum += frames[i].duration;
                            found = (sum >= anim_clock);
                        end
                    end
                    r.frame_valid = 1'b1;
                    r.frame_index = 4'(pick);
                    r.out_x       = frames[pick].x;
                    r.out_y       = frames[pick].y;
                    r.out_w       = frames[pick].w;
                    r.out_h       = frames[pick].h;
                end
            end
            default: ;
        endcase
        r.running = anim_on;
        r.elapsed = sfs_pkg::TIMER_W'(anim_clock);
        return r;
    endfunction

    function automatic sfs_pkg::item_t mk_req(logic [2:0] action, int amount, int x,
                                              int y, int w, int h);
        sfs_pkg::item_t r;
        r.action = action;
        r.amount = 16'(amount);
        r.src_x  = 16'(x);
        r.src_y  = 16'(y);
        r.src_w  = 12'(w);
        r.src_h  = 12'(h);
        return r;
    endfunction

    function automatic sfs_pkg::result_t mk_res(bit run, bit vld, int idx, int x, int y,
                                                int w, int h, bit full, int el);
        sfs_pkg::result_t r;
        r.running     = run;
        r.frame_valid = vld;
        r.frame_index = 4'(idx);
        r.out_x       = 16'(x);
        r.out_y       = 16'(y);
        r.out_w       = 12'(w);
        r.out_h       = 12'(h);
        r.table_full  = full;
        r.elapsed     = sfs_pkg::TIMER_W'(el);
        return r;
    endfunction

    function automatic sfs_pkg::item_t random_request();
        sfs_pkg::item_t r;
        int unsigned    pick;
        r.amount = 16'($urandom_range(0, 65535));
        r.src_x  = 16'($urandom_range(0, 65535));
        r.src_y  = 16'($urandom_range(0, 65535));
        r.src_w  = 12'($urandom_range(0, 4095));
        r.src_h  = 12'($urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            r.action = sfs_pkg::ACT_ADD;
            // Mostly short frames so that ticks reach the end of the strip often.
            case ($urandom_range(0, 5))
                0:       r.amount = '0;
                1, 2, 3: r.amount = 16'($urandom_range(1, 63));
                4:       r.amount = 16'($urandom_range(64, 1023));
                default: ;
            endcase
        end
        else if (pick < 20)
            r.action = sfs_pkg::ACT_START;
        else if (pick < 25)
            r.action = sfs_pkg::ACT_STOP;
        else if (pick < 60)
        begin
            r.action = sfs_pkg::ACT_TICK;
            if ($urandom_range(0, 1) == 0)
                r.amount = 16'($urandom_range(0, 255));
        end
        else if (pick < 97)
            r.action = sfs_pkg::ACT_RENDER;
        else
        begin
            case ($urandom_range(0, 2))
                0:       r.action = ACT_RSVD5;
                1:       r.action = ACT_RSVD6;
                default: r.action = ACT_RSVD7;
            endcase
        end
        return r;
    endfunction

    task automatic flag_field(string name, int want, int got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        mismatches++;
    endtask

    task automatic compare_result(sfs_pkg::result_t w, sfs_pkg::result_t g);
        if (g.running !== w.running)
            flag_field("running", w.running, g.running);
        if (g.frame_valid !== w.frame_valid)
            flag_field("frame_valid", w.frame_valid, g.frame_valid);
        if (g.frame_index !== w.frame_index)
            flag_field("frame_index", w.frame_index, g.frame_index);
        if (g.out_x !== w.out_x)
            flag_field("out_x", w.out_x, g.out_x);
        if (g.out_y !== w.out_y)
            flag_field("out_y", w.out_y, g.out_y);
        if (g.out_w !== w.out_w)
            flag_field("out_w", w.out_w, g.out_w);
        if (g.out_h !== w.out_h)
            flag_field("out_h", w.out_h, g.out_h);
        if (g.table_full !== w.table_full)
            flag_field("table_full", w.table_full, g.table_full);
        if (g.elapsed !== w.elapsed)
            flag_field("elapsed", w.elapsed, g.elapsed);
    endtask

    // Everything the block does is observed here, at the rising edge.
    always @(posedge clk)
    begin
        sfs_pkg::result_t predicted;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t ns: result with no request outstanding", $time);
                    mismatches++;
                end
                else
                    compare_result(expected_results.pop_front(), result);
            end
            if (cfg_valid && cfg_ready === 1'b1)
            begin
                wrap_mode = cfg_data;
                cfg_writes++;
            end
            if (start && busy === 1'b0)
            begin
                predicted = advance_sequencer(item);
                expected_results.insert(expected_results.size(),
                                        use_typed ? typed_want : predicted);
                requests_taken++;
            end
        end
    end

    task automatic put(sfs_pkg::item_t req, bit typed, sfs_pkg::result_t want);
        step_t s;
        s.is_cfg  = 1'b0;
        s.cfg_val = 1'b0;
        s.req     = req;
        s.typed   = typed;
        s.want    = want;
        script.insert(script.size(), s);
    endtask

    task automatic put_cfg(bit v);
        step_t s;
        s.is_cfg  = 1'b1;
        s.cfg_val = v;
        s.req     = '0;
        s.typed   = 1'b0;
        s.want    = '0;
        script.insert(script.size(), s);
    endtask

    task automatic drain_results();
        start = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic send_request(sfs_pkg::item_t req, int unsigned gap);
        int unsigned n;
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item  = req;
        start = 1'b1;
        n     = requests_taken;
        do
            @(negedge clk);
        while (requests_taken == n);
    endtask

    task automatic write_wrap_mode(bit v);
        int unsigned n;
        drain_results();
        cfg_data  = v;
        cfg_valid = 1'b1;
        n         = cfg_writes;
        do
            @(negedge clk);
        while (cfg_writes == n);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        bit no_idle;
        sfs_pkg::result_t none;
        none      = '0;
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;

        // Empty table, stopped, stop-at-end mode.
        put(mk_req(sfs_pkg::ACT_RENDER, 0, 0, 0, 0, 0), 1'b1, none);
        put(mk_req(sfs_pkg::ACT_TICK, 100, 0, 0, 0, 0), 1'b1, none);
        put(mk_req(sfs_pkg::ACT_START, 65535, -1, -1, 4095, 4095), 1'b1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0));
        put(mk_req(sfs_pkg::ACT_RENDER, 0, 0, 0, 0, 0), 1'b1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0));
        // A zero total is reached at once and the animation stops.
        put(mk_req(sfs_pkg::ACT_TICK, 5, 0, 0, 0, 0), 1'b1,
            mk_res(0, 0, 0, 0, 0, 0, 0, 0, 5));
        put_cfg(1'b1);
        put(mk_req(sfs_pkg::ACT_START, 0, 0, 0, 0, 0), 1'b1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0));
        // In wrap mode a zero total clears the timer and keeps running.
        put(mk_req(sfs_pkg::ACT_TICK, 65535, 0, 0, 0, 0), 1'b1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0));
        put(mk_req(sfs_pkg::ACT_ADD, 0, -32768, 32767, 4095, 4095), 1'b1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0));
        put(mk_req(sfs_pkg::ACT_ADD, 65535, 32767, -32768, 0, 0), 1'b1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0, 0));
        put(mk_req(sfs_pkg::ACT_RENDER, 0, 0, 0, 0, 0), 1'b1,
            mk_res(1, 1, 0, -32768, 32767, 4095, 4095, 0, 0));
        put(mk_req(sfs_pkg::ACT_TICK, 1, 0, 0, 0, 0), 1'b1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0, 1));
        put(mk_req(sfs_pkg::ACT_RENDER, 0, 0, 0, 0, 0), 1'b1,
            mk_res(1, 1, 1, 32767, -32768, 0, 0, 0, 1));
        put(mk_req(sfs_pkg::ACT_TICK, 65535, 0, 0, 0, 0), 1'b0, none);
        put(mk_req(sfs_pkg::ACT_ADD, 12345, 4660, -4660, 1365, 2730), 1'b0, none);
        put(mk_req(sfs_pkg::ACT_TICK, 65534, 0, 0, 0, 0), 1'b0, none);
        put(mk_req(sfs_pkg::ACT_RENDER, 0, 0, 0, 0, 0), 1'b0, none);
        put(mk_req(sfs_pkg::ACT_STOP, 0, 0, 0, 0, 0), 1'b0, none);
        put(mk_req(sfs_pkg::ACT_RENDER, 0, 0, 0, 0, 0), 1'b0, none);
        put(mk_req(sfs_pkg::ACT_TICK, 777, 0, 0, 0, 0), 1'b0, none);
        put(mk_req(ACT_RSVD5, 1, 1, 1, 1, 1), 1'b0, none);
        put(mk_req(ACT_RSVD6, 65535, -1, -1, 4095, 4095), 1'b0, none);
        put(mk_req(ACT_RSVD7, 0, 0, 0, 0, 0), 1'b0, none);
        put_cfg(1'b0);
        put(mk_req(sfs_pkg::ACT_START, 0, 0, 0, 0, 0), 1'b0, none);
        put(mk_req(sfs_pkg::ACT_TICK, 65535, 0, 0, 0, 0), 1'b0, none);
        put(mk_req(sfs_pkg::ACT_TICK, 65535, 0, 0, 0, 0), 1'b0, none);

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[k])
        begin
            if (script[k].is_cfg)
                write_wrap_mode(script[k].cfg_val);
            else
            begin
                use_typed  = script[k].typed;
                typed_want = script[k].want;
                send_request(script[k].req, $urandom_range(0, 11));
            end
        end
        use_typed = 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            write_wrap_mode(p % 2 == 0);
            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                // Back-to-back stretches are mixed at random with randomly gapped ones.
                if (k % 32 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 59) == 0)
                    drain_results();
                send_request(random_request(), no_idle ? 0 : $urandom_range(0, 11));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("PASS sprite_frame_sequencer");
        else
            $display("FAIL sprite_frame_sequencer");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("FAIL sprite_frame_sequencer");
        $finish;
    end

endmodule
